### hdl/gmn_pkg.sv
`default_nettype none
package gmn_pkg;

  localparam int NUM_PORTS  = 2;
  localparam int PORT_W     = 1;
  localparam int PORT_IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  localparam logic [7:0]  BUDGET_RESET = 8'd240;
  localparam logic [7:0]  STICK_CENTRE = 8'd128;
  localparam logic [15:0] BUTTON_MASK  = 16'hFFFF;

  typedef enum logic [1:0] {
    LINK_DOWN    = 2'd0,
    LINK_STABLE  = 2'd1,
    LINK_FIND    = 2'd2,
    LINK_NEGOT   = 2'd3
  } link_t;

  typedef enum logic [1:0] {
    REQ_BUSY     = 2'd0,
    REQ_COMPLETE = 2'd1,
    REQ_FAILED   = 2'd2,
    REQ_OTHER    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CMD_NONE      = 2'd0,
    CMD_ANALOG    = 2'd1,
    CMD_PRESSURE  = 2'd2,
    CMD_ALIGNMENT = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_REQ_ANALOG    = 3'd0,
    ST_VERIFY_ANALOG = 3'd1,
    ST_REQ_PRESSURE  = 3'd2,
    ST_CONF_PRESSURE = 3'd3,
    ST_REQ_ALIGN     = 3'd4,
    ST_CONF_ALIGN    = 3'd5,
    ST_DONE          = 3'd6
  } stage_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [1:0]        link_state;
    logic [1:0]        request_status;
    logic              mode_is_analog;
    logic              pressure_capable;
    logic              has_actuators;
    logic              frame_valid;
    logic [15:0]       raw_buttons;
    logic [7:0]        left_x;
    logic [7:0]        left_y;
    logic [7:0]        right_x;
    logic [7:0]        right_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  command;
    logic        is_connected;
    logic        analog_ok;
    logic        pressure_ok;
    logic        rumble_ok;
    logic [15:0] held_buttons;
    logic [15:0] pressed_edges;
    logic [15:0] released_edges;
    logic [7:0]  stick_lx;
    logic [7:0]  stick_ly;
    logic [7:0]  stick_rx;
    logic [7:0]  stick_ry;
  } out_item_t;

  typedef struct packed {
    logic        link_up;
    logic        analog_flag;
    logic        pressure_flag;
    logic        rumble_flag;
    stage_t      stage;
    logic [7:0]  settle_count;
    logic [15:0] button_word;
    logic [7:0]  lx;
    logic [7:0]  ly;
    logic [7:0]  rx;
    logic [7:0]  ry;
  } port_rec_t;

  localparam port_rec_t REC_RESET = '{
    link_up:       1'b0,
    analog_flag:   1'b0,
    pressure_flag: 1'b0,
    rumble_flag:   1'b0,
    stage:         ST_REQ_ANALOG,
    settle_count:  8'd0,
    button_word:   16'd0,
    lx:            STICK_CENTRE,
    ly:            STICK_CENTRE,
    rx:            STICK_CENTRE,
    ry:            STICK_CENTRE
  };

endpackage
`default_nettype wire

### hdl/gmn_port_update.sv
`default_nettype none
module gmn_port_update (
  input  wire gmn_pkg::in_item_t  item,
  input  wire gmn_pkg::port_rec_t rec_cur,
  input  wire logic [7:0]         settle_budget,
  output gmn_pkg::port_rec_t      rec_nxt,
  output gmn_pkg::out_item_t      result
);

  gmn_pkg::port_rec_t rec;
  gmn_pkg::cmd_t      cmd;
  logic [15:0]        prev;
  logic               stable;

  always_comb begin
    rec    = rec_cur;
    cmd    = gmn_pkg::CMD_NONE;
    prev   = rec_cur.button_word;
    stable = (item.link_state == gmn_pkg::LINK_STABLE);

    case (item.link_state)
      gmn_pkg::LINK_DOWN: begin
        rec  = gmn_pkg::REC_RESET;
        prev = '0;
      end
      gmn_pkg::LINK_STABLE, gmn_pkg::LINK_FIND: begin
        if (!rec.link_up) begin
          rec.link_up      = 1'b1;
          rec.settle_count = '0;
        end
        if (rec.stage < gmn_pkg::ST_DONE && rec.settle_count < settle_budget) begin
          rec.settle_count = rec.settle_count + 8'd1;
          if (item.request_status == gmn_pkg::REQ_FAILED &&
              rec.stage inside {gmn_pkg::ST_VERIFY_ANALOG, gmn_pkg::ST_CONF_PRESSURE,
                                gmn_pkg::ST_CONF_ALIGN}) begin
            rec.stage = gmn_pkg::stage_t'(rec.stage - 3'd1);
          end else if (item.request_status == gmn_pkg::REQ_COMPLETE && stable) begin
            case (rec.stage)
              gmn_pkg::ST_REQ_ANALOG: begin
                cmd       = gmn_pkg::CMD_ANALOG;
                rec.stage = gmn_pkg::ST_VERIFY_ANALOG;
              end
              gmn_pkg::ST_VERIFY_ANALOG: begin
                if (item.mode_is_analog) begin
                  rec.analog_flag = 1'b1;
                  rec.stage       = gmn_pkg::ST_REQ_PRESSURE;
                end
              end
              gmn_pkg::ST_REQ_PRESSURE: begin
                if (item.pressure_capable) begin
                  cmd       = gmn_pkg::CMD_PRESSURE;
                  rec.stage = gmn_pkg::ST_CONF_PRESSURE;
                end else begin
                  rec.stage = gmn_pkg::ST_REQ_ALIGN;
                end
              end
              gmn_pkg::ST_CONF_PRESSURE: begin
                rec.pressure_flag = 1'b1;
                rec.stage         = gmn_pkg::ST_REQ_ALIGN;
              end
              gmn_pkg::ST_REQ_ALIGN: begin
                if (item.has_actuators) begin
                  cmd       = gmn_pkg::CMD_ALIGNMENT;
                  rec.stage = gmn_pkg::ST_CONF_ALIGN;
                end else begin
                  rec.stage = gmn_pkg::ST_DONE;
                end
              end
              default: begin
                rec.rumble_flag = 1'b1;
                rec.stage       = gmn_pkg::ST_DONE;
              end
            endcase
          end
        end
        if (item.frame_valid) begin
          rec.button_word = gmn_pkg::BUTTON_MASK ^ item.raw_buttons;
          rec.lx          = item.left_x;
          rec.ly          = item.left_y;
          rec.rx          = item.right_x;
          rec.ry          = item.right_y;
        end
      end
      default: ; // negotiating: record held
    endcase
  end

  assign rec_nxt = rec;

  always_comb begin
    result.command        = cmd;
    result.is_connected   = rec.link_up;
    result.analog_ok      = rec.analog_flag;
    result.pressure_ok    = rec.pressure_flag;
    result.rumble_ok      = rec.rumble_flag;
    result.held_buttons   = rec.button_word;
    result.pressed_edges  = rec.button_word & ~prev;
    result.released_edges = prev & ~rec.button_word;
    result.stick_lx       = rec.lx;
    result.stick_ly       = rec.ly;
    result.stick_rx       = rec.rx;
    result.stick_ry       = rec.ry;
  end

endmodule
`default_nettype wire

### hdl/gamepad_mode_negotiator.sv
// Pipeline: input register in_r, then result register out_r; an item waits in in_r while out_r is stalled.
// Throughput: one poll per cycle while out_ready keeps the result moving; the record update is one pass of logic.
// Polls of the same port in consecutive cycles see the record left by the one before.
// Reset (rst_n low, synchronous): all port records cleared, sticks centred, budget 240,
// both pipeline stages emptied.
`default_nettype none
module gamepad_mode_negotiator (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire gmn_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output gmn_pkg::out_item_t      out_data,
  input  wire                     cfg_we,
  input  wire logic [7:0]         cfg_wdata
);

  logic                    in_v_r;
  gmn_pkg::in_item_t       in_r;
  logic                    out_v_r;
  gmn_pkg::out_item_t      out_r;
  logic [7:0]              budget_r;
  gmn_pkg::port_rec_t      rec_r [gmn_pkg::NUM_PORTS];

  logic                              advance;
  logic                              port_ok;
  logic [gmn_pkg::PORT_IDX_W-1:0]    idx;
  gmn_pkg::port_rec_t                rec_cur;
  gmn_pkg::port_rec_t                rec_nxt;
  gmn_pkg::out_item_t                upd_result;
  gmn_pkg::out_item_t                result;

  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  assign port_ok = (int'(in_r.port) < gmn_pkg::NUM_PORTS);
  assign idx     = gmn_pkg::PORT_IDX_W'(in_r.port);
  assign rec_cur = rec_r[idx];

  gmn_port_update u_update (
    .item          (in_r),
    .rec_cur       (rec_cur),
    .settle_budget (budget_r),
    .rec_nxt       (rec_nxt),
    .result        (upd_result)
  );

  always_comb begin
    if (port_ok) begin
      result = upd_result;
    end else begin
      result          = '0;
      result.stick_lx = gmn_pkg::STICK_CENTRE;
      result.stick_ly = gmn_pkg::STICK_CENTRE;
      result.stick_rx = gmn_pkg::STICK_CENTRE;
      result.stick_ry = gmn_pkg::STICK_CENTRE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      budget_r <= gmn_pkg::BUDGET_RESET;
      for (int p = 0; p < gmn_pkg::NUM_PORTS; p++) begin
        rec_r[p] <= gmn_pkg::REC_RESET;
      end
    end else begin
      if (cfg_we) begin
        budget_r <= cfg_wdata;
      end
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        if (port_ok) begin
          rec_r[idx] <= rec_nxt;
        end
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // a command is only ever issued on a connected port
  a_cmd_connected: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.command != gmn_pkg::CMD_NONE |-> out_data.is_connected)
    else $error("command issued while not connected");

  // pressure and rumble can only be confirmed after analog
  a_flag_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.pressure_ok || out_data.rumble_ok) |-> out_data.analog_ok)
    else $error("capability flag set without analog");

  // back-pressure only when both stages hold an item
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_v_r && out_v_r && !out_ready)
    else $error("input stalled with room in pipeline");

  // a result appears only in the cycle after an item left the input register
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_v_r))
    else $error("result without item");
`endif

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD   = 64;
  localparam int SETTLE_WAIT = 4;
  localparam int SCRIPT_LEN  = 25;
  localparam int SHOW_LIMIT  = 10;

  // what a port shows straight after reset or a disconnect
  localparam gmn_pkg::out_item_t IDLE_REPORT = '{
    gmn_pkg::CMD_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0,
    gmn_pkg::STICK_CENTRE, gmn_pkg::STICK_CENTRE, gmn_pkg::STICK_CENTRE, gmn_pkg::STICK_CENTRE
  };

  typedef struct {
    gmn_pkg::in_item_t  poll;
    bit                 has_fixed;
    gmn_pkg::out_item_t fixed;
  } script_row_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  gmn_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  gmn_pkg::out_item_t out_data;
  logic               cfg_we    = 1'b0;
  logic [7:0]         cfg_wdata = 8'd0;

  // travels alongside in_data so the checker knows which report was typed in
  bit                 has_fixed_now = 1'b0;
  gmn_pkg::out_item_t fixed_now     = '0;

  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  bit long_hold_armed = 1'b0;
  bit long_hold_done  = 1'b0;
  int hold_left       = 0;

  logic [7:0]         budget;
  gmn_pkg::port_rec_t records [gmn_pkg::NUM_PORTS];
  gmn_pkg::out_item_t awaited_reports [$];

  int polls_accepted  = 0;
  int reports_checked = 0;
  int commands_seen   = 0;
  int mismatches      = 0;
  int quiet_cycles    = 0;
  logic [7:0] odd_budget = 8'd0;

  script_row_t script [SCRIPT_LEN];

  always #2 clk = ~clk;

  gamepad_mode_negotiator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  function automatic gmn_pkg::in_item_t mk_poll(input logic [gmn_pkg::PORT_W-1:0] prt,
                                                input gmn_pkg::link_t link,
                                                input gmn_pkg::req_t req,
                                                input logic [3:0] caps,
                                                input logic [15:0] raw,
                                                input logic [31:0] sticks);
    gmn_pkg::in_item_t p;
    p.port           = prt;
    p.link_state     = link;
    p.request_status = req;
    {p.mode_is_analog, p.pressure_capable, p.has_actuators, p.frame_valid} = caps;
    p.raw_buttons    = raw;
    {p.left_x, p.left_y, p.right_x, p.right_y} = sticks;
    return p;
  endfunction

  // record update for one poll; returns the report the block should give
  function automatic gmn_pkg::out_item_t predict_poll(input gmn_pkg::in_item_t p);
    gmn_pkg::port_rec_t r;
    gmn_pkg::out_item_t o;
    logic [15:0]        prev;
    gmn_pkg::cmd_t      cmd;
    int                 idx;
    idx = int'(p.port);
    if (idx >= gmn_pkg::NUM_PORTS)
      return IDLE_REPORT;
    r    = records[idx];
    prev = r.button_word;
    cmd  = gmn_pkg::CMD_NONE;
    case (p.link_state)
      gmn_pkg::LINK_DOWN: begin
        r    = gmn_pkg::REC_RESET;
        prev = '0;
      end
      gmn_pkg::LINK_STABLE, gmn_pkg::LINK_FIND: begin
        if (!r.link_up) begin
          r.link_up      = 1'b1;
          r.settle_count = 8'd0;
        end
        if (r.stage < gmn_pkg::ST_DONE && r.settle_count < budget) begin
          r.settle_count = r.settle_count + 8'd1;
          if (p.request_status == gmn_pkg::REQ_FAILED &&
              (r.stage == gmn_pkg::ST_VERIFY_ANALOG || r.stage == gmn_pkg::ST_CONF_PRESSURE ||
               r.stage == gmn_pkg::ST_CONF_ALIGN)) begin
            r.stage = gmn_pkg::stage_t'(r.stage - 3'd1);
          end else if (p.request_status == gmn_pkg::REQ_COMPLETE &&
                       p.link_state == gmn_pkg::LINK_STABLE) begin
            case (r.stage)
              gmn_pkg::ST_REQ_ANALOG: begin
                cmd     = gmn_pkg::CMD_ANALOG;
                r.stage = gmn_pkg::ST_VERIFY_ANALOG;
              end
              gmn_pkg::ST_VERIFY_ANALOG: begin
                if (p.mode_is_analog) begin
                  r.analog_flag = 1'b1;
                  r.stage       = gmn_pkg::ST_REQ_PRESSURE;
                end
              end
              gmn_pkg::ST_REQ_PRESSURE: begin
                if (p.pressure_capable) begin
                  cmd     = gmn_pkg::CMD_PRESSURE;
                  r.stage = gmn_pkg::ST_CONF_PRESSURE;
                end else begin
                  r.stage = gmn_pkg::ST_REQ_ALIGN;
                end
              end
              gmn_pkg::ST_CONF_PRESSURE: begin
                r.pressure_flag = 1'b1;
                r.stage         = gmn_pkg::ST_REQ_ALIGN;
              end
              gmn_pkg::ST_REQ_ALIGN: begin
                if (p.has_actuators) begin
                  cmd     = gmn_pkg::CMD_ALIGNMENT;
                  r.stage = gmn_pkg::ST_CONF_ALIGN;
                end else begin
                  r.stage = gmn_pkg::ST_DONE;
                end
              end
              gmn_pkg::ST_CONF_ALIGN: begin
                r.rumble_flag = 1'b1;
                r.stage       = gmn_pkg::ST_DONE;
              end
              default: ;
            endcase
          end
        end
        if (p.frame_valid) begin
          r.button_word = ~p.raw_buttons;
          r.lx = p.left_x;
          r.ly = p.left_y;
          r.rx = p.right_x;
          r.ry = p.right_y;
        end
      end
      default: ; // negotiating: record held
    endcase
    records[idx] = r;
    o.command        = cmd;
    o.is_connected   = r.link_up;
    o.analog_ok      = r.analog_flag;
    o.pressure_ok    = r.pressure_flag;
    o.rumble_ok      = r.rumble_flag;
    o.held_buttons   = r.button_word;
    o.pressed_edges  = r.button_word & ~prev;
    o.released_edges = prev & ~r.button_word;
    o.stick_lx       = r.lx;
    o.stick_ly       = r.ly;
    o.stick_rx       = r.rx;
    o.stick_ry       = r.ry;
    return o;
  endfunction

  function automatic string report_text(input gmn_pkg::out_item_t r);
    return {$sformatf("cmd=%0d conn=%b an=%b pr=%b rb=%b ",
                      r.command, r.is_connected, r.analog_ok, r.pressure_ok, r.rumble_ok),
            $sformatf("held=%h press=%h rel=%h sticks=%h %h %h %h",
                      r.held_buttons, r.pressed_edges, r.released_edges,
                      r.stick_lx, r.stick_ly, r.stick_rx, r.stick_ry)};
  endfunction

  // prediction and checking, both sampled at the rising edge
  always @(posedge clk) begin
    gmn_pkg::out_item_t want;
    bit                 moved;
    if (!rst_n) begin
      budget = gmn_pkg::BUDGET_RESET;
      foreach (records[i]) records[i] = gmn_pkg::REC_RESET;
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (cfg_we)
        budget = cfg_wdata;
      if (in_valid && in_ready) begin
        want = predict_poll(in_data);
        awaited_reports.push_back(has_fixed_now ? fixed_now : want);
        polls_accepted++;
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (awaited_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("Unexpected report: %s", report_text(out_data));
        end else begin
          want = awaited_reports.pop_front();
          reports_checked++;
          if (out_data.command != gmn_pkg::CMD_NONE)
            commands_seen++;
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT) begin
              $display("Report %0d expected: %s", reports_checked, report_text(want));
              $display("Report %0d actual:   %s", reports_checked, report_text(out_data));
            end
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // result side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (long_hold_armed && !long_hold_done) begin
      out_ready <= 1'b0;
      hold_left = LONG_HOLD;
      long_hold_done = 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic send_poll(input gmn_pkg::in_item_t poll, input bit fixed_given,
                           input gmn_pkg::out_item_t fixed);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data       <= poll;
    has_fixed_now <= fixed_given;
    fixed_now     <= fixed;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_reports.size() != 0);
  endtask

  task automatic write_budget(input logic [7:0] value);
    drain();
    repeat (SETTLE_WAIT) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] stick_byte();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return gmn_pkg::STICK_CENTRE;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly stable links with completed requests so handshakes run to the end
  function automatic gmn_pkg::in_item_t random_poll();
    gmn_pkg::in_item_t p;
    int                pick;
    p.port = gmn_pkg::PORT_W'($urandom_range(0, 1));
    pick = $urandom_range(99);
    if (pick < 4)       p.link_state = gmn_pkg::LINK_DOWN;
    else if (pick < 74) p.link_state = gmn_pkg::LINK_STABLE;
    else if (pick < 88) p.link_state = gmn_pkg::LINK_FIND;
    else                p.link_state = gmn_pkg::LINK_NEGOT;
    pick = $urandom_range(99);
    if (pick < 60)      p.request_status = gmn_pkg::REQ_COMPLETE;
    else if (pick < 75) p.request_status = gmn_pkg::REQ_BUSY;
    else if (pick < 90) p.request_status = gmn_pkg::REQ_FAILED;
    else                p.request_status = gmn_pkg::REQ_OTHER;
    p.mode_is_analog   = ($urandom_range(99) < 85);
    p.pressure_capable = 1'($urandom_range(0, 1));
    p.has_actuators    = 1'($urandom_range(0, 1));
    p.frame_valid      = ($urandom_range(99) < 80);
    case ($urandom_range(3))
      0:       p.raw_buttons = gmn_pkg::BUTTON_MASK;
      1:       p.raw_buttons = ~(16'h1 << $urandom_range(15));
      default: p.raw_buttons = 16'($urandom);
    endcase
    p.left_x  = stick_byte();
    p.left_y  = stick_byte();
    p.right_x = stick_byte();
    p.right_y = stick_byte();
    return p;
  endfunction

  task automatic run_random(input int count, input bit with_pressure);
    for (int i = 0; i < count; i++) begin
      if (with_pressure && i == count / 4)
        long_hold_armed = 1'b1;
      if (with_pressure && i == count / 2)
        drain();
      send_poll(random_poll(), 1'b0, IDLE_REPORT);
    end
  endtask

  initial begin
    // port 0 walks the whole handshake with steps back; port 1 skips the optional stages
    script[0]  = '{mk_poll(1'b0, gmn_pkg::LINK_DOWN, gmn_pkg::REQ_BUSY, 4'b1111, 16'h0000,
                           32'h0), 1'b1, IDLE_REPORT};
    script[1]  = '{mk_poll(1'b0, gmn_pkg::LINK_NEGOT, gmn_pkg::REQ_COMPLETE, 4'b1111, 16'h0000,
                           32'hFFFFFFFF), 1'b1, IDLE_REPORT};
    script[2]  = '{mk_poll(1'b0, gmn_pkg::LINK_STABLE, gmn_pkg::REQ_COMPLETE, 4'b0001, 16'hFFFF,
                           32'h0),
                   1'b1, '{gmn_pkg::CMD_ANALOG, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0,
                           8'h00, 8'h00, 8'h00, 8'h00}};
    script[3]  = '{mk_poll(1'b0, gmn_pkg::LINK_STABLE, gmn_pkg::REQ_FAILED, 4'b0001, 16'h0000,
                           32'hFFFFFFFF), 1'b0, IDLE_REPORT};
    script[4]  = '{mk_poll(1'b0, gmn_pkg::LINK_STABLE, gmn_pkg::REQ_COMPLETE, 4'b0000, 16'h1234,
                           32'h01020304), 1'b0, IDLE_REPORT};
    script[5]  = '{mk_poll(1'b0, gmn_pkg::LINK_STABLE, gmn_pkg::REQ_COMPLETE, 4'b0111, 16'h0F0F,
                           32'h10203040), 1'b0, IDLE_REPORT};
    script[6]  = '{mk_poll(1'b0, gmn_pkg::LINK_FIND, gmn_pkg::REQ_COMPLETE, 4'b1111, 16'hF0F0,
                           32'h80808080), 1'b0, IDLE_REPORT};
    script[7]  = '{mk_poll(1'b0, gmn_pkg::LINK_STABLE, gmn_pkg::REQ_OTHER, 4'b1111, 16'hFF00,
                           32'h7F7F7F7F), 1'b0, IDLE_REPORT};
    script[8]  = '{mk_poll(1'b0, gmn_pkg::LINK_STABLE, gmn_pkg::REQ_COMPLETE, 4'b1001, 16'h00FF,
                           32'hFF00FF00), 1'b0, IDLE_REPORT};
    script[9]  = '{mk_poll(1'b0, gmn_pkg::LINK_STABLE, gmn_pkg::REQ_COMPLETE, 4'b1101, 16'hFFFE,
                           32'h00FF00FF), 1'b0, IDLE_REPORT};
    script[10] = '{mk_poll(1'b0, gmn_pkg::LINK_FIND, gmn_pkg::REQ_FAILED, 4'b1101, 16'h7FFF,
                           32'h11223344), 1'b0, IDLE_REPORT};
    script[11] = '{mk_poll(1'b0, gmn_pkg::LINK_STABLE, gmn_pkg::REQ_COMPLETE, 4'b1101, 16'hFFFF,
                           32'h55667788), 1'b0, IDLE_REPORT};
    script[12] = '{mk_poll(1'b0, gmn_pkg::LINK_STABLE, gmn_pkg::REQ_COMPLETE, 4'b1001, 16'hBFFF,
                           32'h99AABBCC), 1'b0, IDLE_REPORT};
    script[13] = '{mk_poll(1'b0, gmn_pkg::LINK_STABLE, gmn_pkg::REQ_COMPLETE, 4'b1011, 16'hDFFF,
                           32'hDDEEFF00), 1'b0, IDLE_REPORT};
    script[14] = '{mk_poll(1'b0, gmn_pkg::LINK_STABLE, gmn_pkg::REQ_FAILED, 4'b1011, 16'hEFFF,
                           32'h12345678), 1'b0, IDLE_REPORT};
    script[15] = '{mk_poll(1'b0, gmn_pkg::LINK_STABLE, gmn_pkg::REQ_COMPLETE, 4'b1011, 16'hF7FF,
                           32'h9ABCDEF0), 1'b0, IDLE_REPORT};
    script[16] = '{mk_poll(1'b0, gmn_pkg::LINK_STABLE, gmn_pkg::REQ_COMPLETE, 4'b0001, 16'hFBFF,
                           32'h0F1E2D3C), 1'b0, IDLE_REPORT};
    script[17] = '{mk_poll(1'b0, gmn_pkg::LINK_STABLE, gmn_pkg::REQ_COMPLETE, 4'b1111, 16'hFDFF,
                           32'h4B5A6978), 1'b0, IDLE_REPORT};
    script[18] = '{mk_poll(1'b1, gmn_pkg::LINK_STABLE, gmn_pkg::REQ_COMPLETE, 4'b0001, 16'hAAAA,
                           32'h00000000), 1'b0, IDLE_REPORT};
    script[19] = '{mk_poll(1'b1, gmn_pkg::LINK_STABLE, gmn_pkg::REQ_COMPLETE, 4'b1001, 16'h5555,
                           32'hFFFFFFFF), 1'b0, IDLE_REPORT};
    script[20] = '{mk_poll(1'b1, gmn_pkg::LINK_STABLE, gmn_pkg::REQ_COMPLETE, 4'b1001, 16'hAAAA,
                           32'h80FF0080), 1'b0, IDLE_REPORT};
    script[21] = '{mk_poll(1'b1, gmn_pkg::LINK_STABLE, gmn_pkg::REQ_COMPLETE, 4'b1000, 16'h0000,
                           32'h00000000), 1'b0, IDLE_REPORT};
    script[22] = '{mk_poll(1'b1, gmn_pkg::LINK_NEGOT, gmn_pkg::REQ_COMPLETE, 4'b1111, 16'h0000,
                           32'h01010101), 1'b0, IDLE_REPORT};
    script[23] = '{mk_poll(1'b0, gmn_pkg::LINK_DOWN, gmn_pkg::REQ_COMPLETE, 4'b1111, 16'h0000,
                           32'hFFFFFFFF), 1'b1, IDLE_REPORT};
    script[24] = '{mk_poll(1'b1, gmn_pkg::LINK_STABLE, gmn_pkg::REQ_BUSY, 4'b1111, 16'hFFFF,
                           32'h7F807F80), 1'b0, IDLE_REPORT};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct  = 12;
    out_idle_pct = 80;
    foreach (script[i])
      send_poll(script[i].poll, script[i].has_fixed, script[i].fixed);

    write_budget(8'd255);
    run_random(400, 1'b0);

    in_idle_pct  = 80;
    out_idle_pct = 12;
    write_budget(8'd0);
    run_random(300, 1'b0);

    // a tight budget so handshakes run out of polls
    in_idle_pct  = 0;
    out_idle_pct = 0;
    write_budget(8'd5);
    run_random(450, 1'b1);

    odd_budget = 8'($urandom_range(1, 254));
    write_budget(odd_budget);
    run_random(450, 1'b0);

    drain();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (awaited_reports.size() != 0) begin
      $display("%0d reports never arrived", awaited_reports.size());
      mismatches += awaited_reports.size();
    end

    $display("Ran %0d polls (%0d scripted) under poll budgets 240, 255, 0, 5 and %0d,",
             polls_accepted, SCRIPT_LEN, odd_budget);
    $display("with both stall patterns and a long output hold; %0d reports checked, %0d cmds.",
             reports_checked, commands_seen);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
